// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcrs_pkg.sv =====
`default_nettype none
package pcrs_pkg;

  localparam int CHANNEL_COUNT  = 8;
  localparam int PRIORITY_COUNT = 8;

  // fixed field widths
  localparam int CH_W         = 3;
  localparam int PRIO_FIELD_W = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int LEVELS_W     = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int LVLN_W       = 5;

  localparam int CH_IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int LVL_IDX_W = (PRIORITY_COUNT > 1) ? $clog2(PRIORITY_COUNT) : 1;
  localparam int PTR_W     = $clog2(CHANNEL_COUNT + 1);

  // empty / end-of-list pointer
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CHANNEL_COUNT);

  localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_PRIO   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PRIO_LEVELS = CFG_INDEX_W'(1);
  localparam logic [LEVELS_W-1:0]    LEVELS_RESET    = LEVELS_W'(8);

  typedef enum logic [1:0] {
    OP_CREDIT_REQ = 2'd0,
    OP_DATA_REQ   = 2'd1,
    OP_PICK       = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    GRANT_NONE   = 2'd0,
    GRANT_CREDIT = 2'd1,
    GRANT_DATA   = 2'd2
  } grant_t;

  typedef struct packed {
    logic                 enq;
    logic                 deq;
    logic [CH_IDX_W-1:0]  ch;
    logic [LVL_IDX_W-1:0] prio;
    logic [LVLN_W-1:0]    levels;
  } q_ctrl_t;

  typedef struct packed {
    logic                hit;
    logic [CH_IDX_W-1:0] ch;
  } q_stat_t;

  // levels in use, clamped to 1..PRIORITY_COUNT
  function automatic logic [LVLN_W-1:0] levels_in_use(input logic [LEVELS_W-1:0] lv);
    logic [LVLN_W-1:0] n;
    n = LVLN_W'(lv);
    if (n == '0) n = LVLN_W'(1);
    if (n > LVLN_W'(PRIORITY_COUNT)) n = LVLN_W'(PRIORITY_COUNT);
    return n;
  endfunction

  // configured priority of a channel, clamped to the top level in use
  function automatic logic [LVL_IDX_W-1:0] prio_of(input logic [CH_W-1:0] ch,
                                                  input logic [CFG_DATA_W-1:0] prios,
                                                  input logic [LVLN_W-1:0] n);
    logic [LVLN_W-1:0] p;
    p = LVLN_W'(prios[PRIO_FIELD_W*ch +: PRIO_FIELD_W]);
    if (p >= n) p = n - LVLN_W'(1);
    return LVL_IDX_W'(p);
  endfunction

endpackage
`default_nettype wire

// ===== sv/pcrs_queue.sv =====
`default_nettype none
module pcrs_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pcrs_pkg::q_ctrl_t ctrl,
  output pcrs_pkg::q_stat_t    stat
);

  logic                       pend_r    [pcrs_pkg::CHANNEL_COUNT];
  logic                       pend_nxt  [pcrs_pkg::CHANNEL_COUNT];
  logic [pcrs_pkg::PTR_W-1:0] link_r    [pcrs_pkg::CHANNEL_COUNT];
  logic [pcrs_pkg::PTR_W-1:0] link_nxt  [pcrs_pkg::CHANNEL_COUNT];
  logic [pcrs_pkg::PTR_W-1:0] head_r    [pcrs_pkg::PRIORITY_COUNT];
  logic [pcrs_pkg::PTR_W-1:0] head_nxt  [pcrs_pkg::PRIORITY_COUNT];
  logic [pcrs_pkg::PTR_W-1:0] tail_r    [pcrs_pkg::PRIORITY_COUNT];
  logic [pcrs_pkg::PTR_W-1:0] tail_nxt  [pcrs_pkg::PRIORITY_COUNT];

  logic                           found;
  logic [pcrs_pkg::LVL_IDX_W-1:0] sel;
  logic [pcrs_pkg::CH_IDX_W-1:0]  gch;
  logic [pcrs_pkg::PTR_W-1:0]     nx;
  logic [pcrs_pkg::PTR_W-1:0]     t;

  // highest non-empty level below the levels in use
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = pcrs_pkg::PRIORITY_COUNT - 1; i >= 0; i--) begin
      if (!found && (pcrs_pkg::LVLN_W'(i) < ctrl.levels) &&
          (head_r[i] < pcrs_pkg::NIL_PTR)) begin
        found = 1'b1;
        sel   = pcrs_pkg::LVL_IDX_W'(i);
      end
    end
  end

  assign gch       = pcrs_pkg::CH_IDX_W'(head_r[sel]);
  assign nx        = link_r[gch];
  assign t         = tail_r[ctrl.prio];
  assign stat.hit  = found;
  assign stat.ch   = found ? gch : '0;

  always_comb begin
    pend_nxt = pend_r;
    link_nxt = link_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctrl.enq && !pend_r[ctrl.ch]) begin
      pend_nxt[ctrl.ch] = 1'b1;
      link_nxt[ctrl.ch] = pcrs_pkg::NIL_PTR;
      if ((head_r[ctrl.prio] >= pcrs_pkg::NIL_PTR) || (t >= pcrs_pkg::NIL_PTR)) begin
        head_nxt[ctrl.prio] = pcrs_pkg::PTR_W'(ctrl.ch);
      end else begin
        link_nxt[pcrs_pkg::CH_IDX_W'(t)] = pcrs_pkg::PTR_W'(ctrl.ch);
      end
      tail_nxt[ctrl.prio] = pcrs_pkg::PTR_W'(ctrl.ch);
    end
    if (ctrl.deq && found) begin
      head_nxt[sel] = nx;
      if (nx >= pcrs_pkg::NIL_PTR) begin
        head_nxt[sel] = pcrs_pkg::NIL_PTR;
        tail_nxt[sel] = pcrs_pkg::NIL_PTR;
      end
      link_nxt[gch] = pcrs_pkg::NIL_PTR;
      pend_nxt[gch] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < pcrs_pkg::CHANNEL_COUNT; c++) begin
        pend_r[c] <= 1'b0;
        link_r[c] <= pcrs_pkg::NIL_PTR;
      end
      for (int p = 0; p < pcrs_pkg::PRIORITY_COUNT; p++) begin
        head_r[p] <= pcrs_pkg::NIL_PTR;
        tail_r[p] <= pcrs_pkg::NIL_PTR;
      end
    end else begin
      pend_r <= pend_nxt;
      link_r <= link_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/priority_channel_request_scheduler_top.sv =====
// strict-priority scheduler over two request classes, credit update and data
// input channel: one beat per request or pick (in_operation, in_channel)
//   credit and data requests queue a channel on its configured level and
//   give no result beat; a pick grants the head of the highest non-empty
//   level, credit class first, and gives exactly one result beat
// result channel: out_grant_kind / out_grant_channel, one beat per pick
// latency: the result of a pick is on out_* the cycle after its input beat
// throughput: one beat per cycle while in_ready is high; the level scan and queue update are
//   combinational logic ahead of the queue state and result registers
// stall: in_ready drops only while a result waits and out_ready is low; a
//   stalled result holds unchanged until taken
// reset: rst_n synchronous, active low; every queue empties, all pending
//   marks clear, priorities go to 0 and level count to 8
// configuration: cfg_we / cfg_index / cfg_wdata, to be written only while idle (a duty of the user, not enforced)
`default_nettype none
module priority_channel_request_scheduler_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request / pick beats
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_operation,
  input  wire logic [pcrs_pkg::CH_W-1:0]         in_channel,
  // grant beats
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_grant_kind,
  output logic [pcrs_pkg::CH_W-1:0]              out_grant_channel,
  // register writes
  input  wire logic                              cfg_we,
  input  wire logic [pcrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pcrs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [pcrs_pkg::CFG_DATA_W-1:0] chan_prio_r;
  logic [pcrs_pkg::LEVELS_W-1:0]   prio_levels_r;

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [1:0]                    grant_kind_r;
  logic [1:0]                    grant_kind_nxt;
  logic [pcrs_pkg::CH_W-1:0]     grant_ch_r;
  logic [pcrs_pkg::CH_W-1:0]     grant_ch_nxt;

  logic                          accept;
  logic                          ch_ok;
  logic                          is_pick;
  logic [pcrs_pkg::LVLN_W-1:0]   levels;
  logic [pcrs_pkg::LVL_IDX_W-1:0] prio;

  pcrs_pkg::q_ctrl_t credit_ctrl;
  pcrs_pkg::q_ctrl_t data_ctrl;
  pcrs_pkg::q_stat_t credit_stat;
  pcrs_pkg::q_stat_t data_stat;

  // the result register frees up when its beat is taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_pick  = (in_operation == pcrs_pkg::OP_PICK);
  // channels beyond the count are dropped
  assign ch_ok    = (32'(in_channel) < pcrs_pkg::CHANNEL_COUNT);
  assign levels   = pcrs_pkg::levels_in_use(prio_levels_r);
  assign prio     = pcrs_pkg::prio_of(in_channel, chan_prio_r, levels);

  always_comb begin
    credit_ctrl.enq    = accept && ch_ok && (in_operation == pcrs_pkg::OP_CREDIT_REQ);
    credit_ctrl.deq    = accept && is_pick;
    credit_ctrl.ch     = pcrs_pkg::CH_IDX_W'(in_channel);
    credit_ctrl.prio   = prio;
    credit_ctrl.levels = levels;
    data_ctrl.enq      = accept && ch_ok && (in_operation == pcrs_pkg::OP_DATA_REQ);
    // data class is only served when no credit update waits
    data_ctrl.deq      = accept && is_pick && !credit_stat.hit;
    data_ctrl.ch       = pcrs_pkg::CH_IDX_W'(in_channel);
    data_ctrl.prio     = prio;
    data_ctrl.levels   = levels;
  end

  pcrs_queue u_credit_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (credit_ctrl),
    .stat  (credit_stat)
  );

  pcrs_queue u_data_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (data_ctrl),
    .stat  (data_stat)
  );

  // result register: loaded by a pick, emptied when taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    grant_kind_nxt = grant_kind_r;
    grant_ch_nxt   = grant_ch_r;
    if (accept && is_pick) begin
      out_valid_nxt = 1'b1;
      if (credit_stat.hit) begin
        grant_kind_nxt = pcrs_pkg::GRANT_CREDIT;
        grant_ch_nxt   = pcrs_pkg::CH_W'(credit_stat.ch);
      end else if (data_stat.hit) begin
        grant_kind_nxt = pcrs_pkg::GRANT_DATA;
        grant_ch_nxt   = pcrs_pkg::CH_W'(data_stat.ch);
      end else begin
        grant_kind_nxt = pcrs_pkg::GRANT_NONE;
        grant_ch_nxt   = '0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    grant_kind_r <= grant_kind_nxt;
    grant_ch_r   <= grant_ch_nxt;
  end

  // configuration registers; unknown indices are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_prio_r   <= '0;
      prio_levels_r <= pcrs_pkg::LEVELS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcrs_pkg::CFG_CHAN_PRIO:   chan_prio_r   <= cfg_wdata;
        pcrs_pkg::CFG_PRIO_LEVELS: prio_levels_r <= cfg_wdata[pcrs_pkg::LEVELS_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_grant_kind    = grant_kind_r;
  assign out_grant_channel = grant_ch_r;

endmodule
`default_nettype wire

// ===== sv/pcrs_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module pcrs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [1:0]                       in_operation,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [1:0]                       out_grant_kind,
  input wire logic [pcrs_pkg::CH_W-1:0]        out_grant_channel
);

  logic in_beat;
  logic pick_beat;
  logic req_beat;

  assign in_beat   = in_valid && in_ready;
  assign pick_beat = in_beat && (in_operation == pcrs_pkg::OP_PICK);
  assign req_beat  = in_beat && (in_operation != pcrs_pkg::OP_PICK);

  // stalled grant holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_grant_kind) && $stable(out_grant_channel), "stalled grant changed")

  // every pick gives a grant beat next cycle
  `ASSERT_NEXT(a_pick_result, clk, rst_n, pick_beat, out_valid, "pick gave no grant beat")

  // requests never create a grant beat
  `ASSERT_NEXT(a_req_silent, clk, rst_n, req_beat && !out_valid, !out_valid, "request made a grant beat")

  // an empty grant names channel zero
  `ASSERT_SAME(a_none_zero, clk, rst_n, out_valid && (out_grant_kind == pcrs_pkg::GRANT_NONE), out_grant_channel == '0, "empty grant with channel set")

endmodule

bind priority_channel_request_scheduler_top pcrs_checker u_pcrs_checker (.*);
`default_nettype wire
